>>> src/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned NowWidth    = 32;
  localparam int unsigned ThrWidth    = 16;
  localparam int unsigned StatusWidth = 8;
  localparam int unsigned EventWidth  = 3;
  localparam int unsigned CfgIdxWidth = 4;

  localparam logic [EventWidth-1:0] EV_NONE        = 3'd0;
  localparam logic [EventWidth-1:0] EV_BUTTON_SHORT = 3'd1;
  localparam logic [EventWidth-1:0] EV_BUTTON_LONG  = 3'd2;
  localparam logic [EventWidth-1:0] EV_POWER_LONG   = 3'd3;
  localparam logic [EventWidth-1:0] EV_POWER_SHORT  = 3'd4;

  localparam logic [StatusWidth-1:0] KEY_SHORT_BIT = 8'h08;
  localparam logic [StatusWidth-1:0] KEY_LONG_BIT  = 8'h04;
  localparam logic [StatusWidth-1:0] KEY_MASK      = KEY_SHORT_BIT | KEY_LONG_BIT;

  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE    = 4'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_PRESS  = 4'd1;
  localparam logic [CfgIdxWidth-1:0] REG_STATUS_POLL = 4'd2;
  localparam logic [CfgIdxWidth-1:0] REG_STATUS_EN   = 4'd3;

  localparam logic [ThrWidth-1:0] DEBOUNCE_RST    = 16'd35;
  localparam logic [ThrWidth-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [ThrWidth-1:0] STATUS_POLL_RST = 16'd50;

  typedef struct packed {
    logic [ThrWidth-1:0] debounce_ticks;
    logic [ThrWidth-1:0] long_press_ticks;
    logic [ThrWidth-1:0] status_poll_ticks;
    logic                status_enable;
  } cfg_t;

  typedef struct packed {
    logic [NowWidth-1:0]    now_tick;
    logic                   level_pressed;
    logic                   status_ok;
    logic [StatusWidth-1:0] key_status;
  } item_t;

  typedef struct packed {
    logic [EventWidth-1:0]  event_code;
    logic [StatusWidth-1:0] clear_mask;
    logic                   status_sampled;
  } res_t;

endpackage

>>> src/bdpc_cfg.sv
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration register file: thresholds and status enable.
// ----------------------------------------------------------------------------
module bdpc_cfg
  import bdpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [ThrWidth-1:0]    cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= DEBOUNCE_RST;
      cfg_q.long_press_ticks  <= LONG_PRESS_RST;
      cfg_q.status_poll_ticks <= STATUS_POLL_RST;
      cfg_q.status_enable     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE:    cfg_q.debounce_ticks    <= cfg_data_i;
        REG_LONG_PRESS:  cfg_q.long_press_ticks  <= cfg_data_i;
        REG_STATUS_POLL: cfg_q.status_poll_ticks <= cfg_data_i;
        REG_STATUS_EN:   cfg_q.status_enable     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce state, press timing and status sampling for one item per cycle while step_i is high.
// ----------------------------------------------------------------------------
module bdpc_core
  import bdpc_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic                  cand_lvl_q, cand_lvl_d;
  logic                  stable_q, stable_d;
  logic                  long_rep_q, long_rep_d;
  logic [TICK_WIDTH-1:0] cand_start_q, cand_start_d;
  logic [TICK_WIDTH-1:0] press_start_q, press_start_d;
  logic [TICK_WIDTH-1:0] last_poll_q, last_poll_d;

  logic [TICK_WIDTH-1:0] now_w;
  logic [TICK_WIDTH-1:0] el_cand, el_press, el_poll;
  logic                  lvl, deb_fire, long_mid, short_ev, long_ev, poll, smp;
  logic [StatusWidth-1:0] bits;

  always_comb begin
    now_w    = TICK_WIDTH'(item_i.now_tick);
    lvl      = item_i.level_pressed;
    el_cand  = now_w - cand_start_q;
    deb_fire = (lvl == cand_lvl_q) && (lvl != stable_q) &&
               (el_cand >= TICK_WIDTH'(cfg_i.debounce_ticks));

    cand_lvl_d   = lvl;
    cand_start_d = (lvl != cand_lvl_q) ? now_w : cand_start_q;

    stable_d      = deb_fire ? lvl : stable_q;
    press_start_d = (deb_fire && lvl) ? now_w : press_start_q;
    long_mid      = (deb_fire && lvl) ? 1'b0 : long_rep_q;
    short_ev      = deb_fire && !lvl && !long_rep_q;

    el_press   = now_w - press_start_d;
    long_ev    = !short_ev && stable_d && !long_mid &&
                 (el_press >= TICK_WIDTH'(cfg_i.long_press_ticks));
    long_rep_d = long_ev | long_mid;

    el_poll     = now_w - last_poll_q;
    poll        = !short_ev && !long_ev && cfg_i.status_enable &&
                  (el_poll >= TICK_WIDTH'(cfg_i.status_poll_ticks));
    last_poll_d = poll ? now_w : last_poll_q;

    smp  = poll && item_i.status_ok;
    bits = smp ? (item_i.key_status & KEY_MASK) : '0;

    res_o.clear_mask     = bits;
    res_o.status_sampled = smp;
    if (short_ev) begin
      res_o.event_code = EV_BUTTON_SHORT;
    end else if (long_ev) begin
      res_o.event_code = EV_BUTTON_LONG;
    end else if ((bits & KEY_LONG_BIT) != '0) begin
      res_o.event_code = EV_POWER_LONG;
    end else if ((bits & KEY_SHORT_BIT) != '0) begin
      res_o.event_code = EV_POWER_SHORT;
    end else begin
      res_o.event_code = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_lvl_q    <= 1'b0;
      stable_q      <= 1'b0;
      long_rep_q    <= 1'b0;
      cand_start_q  <= '0;
      press_start_q <= '0;
      last_poll_q   <= '0;
    end else if (step_i) begin
      cand_lvl_q    <= cand_lvl_d;
      stable_q      <= stable_d;
      long_rep_q    <= long_rep_d;
      cand_start_q  <= cand_start_d;
      press_start_q <= press_start_d;
      last_poll_q   <= last_poll_d;
    end
  end

endmodule

>>> src/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Button debouncer with short/long press events and power-key status sampling.
// ----------------------------------------------------------------------------
// Each input item is one poll: tick timestamp, raw button level, and a status
// byte with its read-ok flag. Each item yields exactly one result item:
// event code, clear mask for the status byte, and a sampled flag.
// Input and output channels use valid/ready; the configuration channel takes
// a register index and 16-bit data and is always ready. Write it only while
// no item is in flight.
// An accepted item lands in the input register; once the output register is
// free or being read, the state update and classification run and the result
// is loaded into the output register, which offers it to the receiver.
// Throughput is one item per cycle unless the receiver stalls, set by the
// single state update per cycle.
// When the receiver stalls, the result holds and one further item waits in
// the input register; input ready drops only when both registers are full.
// Reset clears the core's timestamps and levels to zero (released), loads the
// default thresholds and sets the status enable.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit
  import bdpc_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [ThrWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NowWidth-1:0]    now_tick_i,
  input  logic                   level_pressed_i,
  input  logic                   status_ok_i,
  input  logic [StatusWidth-1:0] key_status_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [EventWidth-1:0]  event_code_o,
  output logic [StatusWidth-1:0] clear_mask_o,
  output logic                   status_sampled_o
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q, adv;

  bdpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdpc_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.now_tick      <= now_tick_i;
      item_q.level_pressed <= level_pressed_i;
      item_q.status_ok     <= status_ok_i;
      item_q.key_status    <= key_status_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_code_o     = res_q.event_code;
  assign clear_mask_o     = res_q.clear_mask;
  assign status_sampled_o = res_q.status_sampled;

endmodule

>>> src/bdpc_chk.sv
// ----------------------------------------------------------------------------
// bdpc_chk
// Port-level checks for the button debounce and press classifier.
// ----------------------------------------------------------------------------
module bdpc_chk
  import bdpc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [EventWidth-1:0]  event_code_o,
  input logic [StatusWidth-1:0] clear_mask_o,
  input logic                   status_sampled_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o) &&
    $stable(clear_mask_o) && $stable(status_sampled_o))
    else $error("result changed while stalled");

  a_mask_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((clear_mask_o & ~KEY_MASK) == '0) &&
    (status_sampled_o || clear_mask_o == '0))
    else $error("clear mask outside sampled key bits");

  a_power_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_code_o == EV_POWER_LONG) == (clear_mask_o[2] == 1'b1)) &&
    ((event_code_o == EV_POWER_SHORT) ==
     (clear_mask_o[3] == 1'b1 && clear_mask_o[2] == 1'b0)))
    else $error("power event does not match clear mask");

  a_button_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_code_o == EV_BUTTON_SHORT || event_code_o == EV_BUTTON_LONG)
    |-> !status_sampled_o)
    else $error("status sampled alongside a button event");

endmodule

bind button_debounce_press_classifier_unit bdpc_chk u_bdpc_chk (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_debounce_press_classifier_unit. A short
// table of polls walks through reset behaviour, status sampling, long and
// short presses, glitches, tick wrap and zero or disabled thresholds; then
// random press and release sequences run under several register settings.
// Every result item is checked against a cycle-free model of the classifier.
// ----------------------------------------------------------------------------
module testbench;
  import bdpc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    bit   typed;
    res_t want;
  } row_check_t;

  typedef struct {
    bit          is_setting;
    cfg_t        setting;
    item_t       poll;
    bit          typed;
    res_t        want;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [ThrWidth-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [NowWidth-1:0]    now_tick_i;
  logic                   level_pressed_i;
  logic                   status_ok_i;
  logic [StatusWidth-1:0] key_status_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [EventWidth-1:0]  event_code_o;
  logic [StatusWidth-1:0] clear_mask_o;
  logic                   status_sampled_o;

  button_debounce_press_classifier_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .now_tick_i      (now_tick_i),
    .level_pressed_i (level_pressed_i),
    .status_ok_i     (status_ok_i),
    .key_status_i    (key_status_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_code_o    (event_code_o),
    .clear_mask_o    (clear_mask_o),
    .status_sampled_o(status_sampled_o)
  );

  always #4 clk_i = ~clk_i;

  // classifier model state
  cfg_t                cfg_model;
  logic                seen_level;
  logic                held_level;
  logic [NowWidth-1:0] seen_since;
  logic [NowWidth-1:0] press_since;
  logic                long_done;
  logic [NowWidth-1:0] last_sample;

  res_t        pending_results[$];
  row_check_t  row_checks[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned polls_sent    = 0;
  int unsigned settings_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned burst_left    = 0;
  int unsigned ev_seen[5]    = '{0, 0, 0, 0, 0};
  int unsigned samples_seen  = 0;
  bit          rx_hold_req   = 1'b0;
  bit          rx_hold_done  = 1'b0;

  task automatic classify_poll(input item_t p, output res_t r);
    logic                done;
    logic [NowWidth-1:0] dt;
    r    = '0;
    done = 1'b0;
    if (p.level_pressed != seen_level) begin
      seen_level = p.level_pressed;
      seen_since = p.now_tick;
    end else if (p.level_pressed != held_level) begin
      dt = p.now_tick - seen_since;
      if (dt >= cfg_model.debounce_ticks) begin
        held_level = p.level_pressed;
        if (p.level_pressed) begin
          press_since = p.now_tick;
          long_done   = 1'b0;
        end else if (!long_done) begin
          r.event_code = EV_BUTTON_SHORT;
          done         = 1'b1;
        end
      end
    end
    dt = p.now_tick - press_since;
    if (!done && held_level && !long_done && dt >= cfg_model.long_press_ticks) begin
      long_done    = 1'b1;
      r.event_code = EV_BUTTON_LONG;
      done         = 1'b1;
    end
    dt = p.now_tick - last_sample;
    if (!done && cfg_model.status_enable && dt >= cfg_model.status_poll_ticks) begin
      last_sample = p.now_tick;
      if (p.status_ok) begin
        r.status_sampled = 1'b1;
        r.clear_mask     = p.key_status & KEY_MASK;
        if ((r.clear_mask & KEY_LONG_BIT) != '0) begin
          r.event_code = EV_POWER_LONG;
        end else if ((r.clear_mask & KEY_SHORT_BIT) != '0) begin
          r.event_code = EV_POWER_SHORT;
        end
      end
    end
  endtask

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    res_t       got;
    res_t       want;
    item_t      poll;
    row_check_t chk;
    if (!rst_ni) begin
      cfg_model.debounce_ticks    = DEBOUNCE_RST;
      cfg_model.long_press_ticks  = LONG_PRESS_RST;
      cfg_model.status_poll_ticks = STATUS_POLL_RST;
      cfg_model.status_enable     = 1'b1;
      seen_level  = 1'b0;
      held_level  = 1'b0;
      seen_since  = '0;
      press_since = '0;
      long_done   = 1'b0;
      last_sample = '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.event_code     = event_code_o;
        got.clear_mask     = clear_mask_o;
        got.status_sampled = status_sampled_o;
        if (got.event_code <= EV_POWER_SHORT) ev_seen[got.event_code]++;
        if (got.status_sampled) samples_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: ev=%0d clr=%02h smp=%0d",
                               got.event_code, got.clear_mask, got.status_sampled));
        end else begin
          want = pending_results.pop_front();
          if (got.event_code !== want.event_code || got.clear_mask !== want.clear_mask ||
              got.status_sampled !== want.status_sampled) begin
            flag_error($sformatf("exp ev=%0d clr=%02h smp=%0d, got ev=%0d clr=%02h smp=%0d",
                                 want.event_code, want.clear_mask, want.status_sampled,
                                 got.event_code, got.clear_mask, got.status_sampled));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_DEBOUNCE:    cfg_model.debounce_ticks    = cfg_data_i;
          REG_LONG_PRESS:  cfg_model.long_press_ticks  = cfg_data_i;
          REG_STATUS_POLL: cfg_model.status_poll_ticks = cfg_data_i;
          REG_STATUS_EN:   cfg_model.status_enable     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        poll.now_tick      = now_tick_i;
        poll.level_pressed = level_pressed_i;
        poll.status_ok     = status_ok_i;
        poll.key_status    = key_status_i;
        classify_poll(poll, want);
        if (row_checks.size() != 0) begin
          chk = row_checks.pop_front();
          if (chk.typed) want = chk.want;
        end
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : rx_pacing
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    seg_left    = 0;
    mode        = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        hold_left    = 400;
        rx_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 128);
        end
        seg_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_poll(input item_t p, input bit typed, input res_t want);
    row_check_t chk;
    chk.typed = typed;
    chk.want  = want;
    row_checks.push_back(chk);
    in_valid_i      <= 1'b1;
    now_tick_i      <= p.now_tick;
    level_pressed_i <= p.level_pressed;
    status_ok_i     <= p.status_ok;
    key_status_i    <= p.key_status;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
  endtask

  task automatic send_paced(input item_t p, input bit gaps_on);
    send_poll(p, 1'b0, '0);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [ThrWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(input cfg_t c);
    drain_wait();
    write_reg(REG_DEBOUNCE, c.debounce_ticks);
    write_reg(REG_LONG_PRESS, c.long_press_ticks);
    write_reg(REG_STATUS_POLL, c.status_poll_ticks);
    write_reg(REG_STATUS_EN, {15'($urandom), c.status_enable});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_cnt++;
  endtask

  function automatic cfg_t mk_cfg(input int unsigned dbn, input int unsigned lng,
                                  input int unsigned prd, input bit en);
    cfg_t c;
    c.debounce_ticks    = ThrWidth'(dbn);
    c.long_press_ticks  = ThrWidth'(lng);
    c.status_poll_ticks = ThrWidth'(prd);
    c.status_enable     = en;
    return c;
  endfunction

  function automatic plan_row_t poll_row(input logic [NowWidth-1:0] now, input bit lvl,
                                         input bit ok, input logic [StatusWidth-1:0] ks);
    plan_row_t r;
    r.is_setting         = 1'b0;
    r.setting            = '0;
    r.poll.now_tick      = now;
    r.poll.level_pressed = lvl;
    r.poll.status_ok     = ok;
    r.poll.key_status    = ks;
    r.typed              = 1'b0;
    r.want               = '0;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [NowWidth-1:0] now, input bit lvl,
                                          input bit ok, input logic [StatusWidth-1:0] ks,
                                          input logic [EventWidth-1:0] ev,
                                          input logic [StatusWidth-1:0] clr, input bit smp);
    plan_row_t r;
    r                     = poll_row(now, lvl, ok, ks);
    r.typed               = 1'b1;
    r.want.event_code     = ev;
    r.want.clear_mask     = clr;
    r.want.status_sampled = smp;
    return r;
  endfunction

  function automatic plan_row_t setting_row(input cfg_t c);
    plan_row_t r;
    r            = poll_row('0, 1'b0, 1'b0, '0);
    r.is_setting = 1'b1;
    r.setting    = c;
    return r;
  endfunction

  task automatic run_phase(input cfg_t c, input int unsigned n_items, input bit gaps_on,
                           input bit long_hold, input bit pause_mid);
    item_t               p;
    int unsigned         sent;
    int unsigned         kind;
    int unsigned         dur;
    int unsigned         held;
    int unsigned         step;
    int unsigned         step_max;
    int unsigned         reps;
    int unsigned         dbn;
    int unsigned         lng;
    bit                  paused;
    logic                lvl;
    logic [NowWidth-1:0] tick;
    apply_setting(c);
    dbn      = c.debounce_ticks;
    lng      = c.long_press_ticks;
    step_max = (dbn + lng) / 8 + 2;
    sent     = 0;
    paused   = 1'b0;
    lvl      = 1'b0;
    tick     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
    burst_left = $urandom_range(1, 24);
    if (long_hold) rx_hold_req = 1'b1;
    while (sent < n_items) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        reps = $urandom_range(1, 3);
        for (int unsigned k = 0; k < reps; k++) begin
          p.now_tick      = $urandom;
          p.level_pressed = 1'($urandom_range(0, 1));
          p.status_ok     = 1'($urandom_range(0, 1));
          p.key_status    = StatusWidth'($urandom);
          send_paced(p, gaps_on);
          sent++;
        end
        tick = p.now_tick;
        lvl  = p.level_pressed;
      end else begin
        if ($urandom_range(0, 3) != 0) lvl = ~lvl;
        if (kind <= 3) begin
          dur = (dbn == 0) ? 0 : $urandom_range(0, dbn - 1);
        end else if (kind <= 9) begin
          dur = dbn + $urandom_range(0, (lng > 1) ? lng - 1 : 0);
        end else begin
          dur = dbn + lng + $urandom_range(0, lng / 2 + 16);
        end
        held = 0;
        do begin
          step            = $urandom_range(0, step_max);
          tick            = tick + step;
          held            = held + step;
          p.now_tick      = tick;
          p.level_pressed = lvl;
          p.status_ok     = ($urandom_range(0, 7) != 0);
          p.key_status    = StatusWidth'($urandom);
          send_paced(p, gaps_on);
          sent++;
        end while (held < dur && sent < n_items);
      end
      if (pause_mid && !paused && sent >= n_items / 2) begin
        drain_wait();
        paused = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    plan_row_t plan[$];
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    now_tick_i      = '0;
    level_pressed_i = 1'b0;
    status_ok_i     = 1'b0;
    key_status_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(known_row(32'd0, 1'b0, 1'b1, 8'hFF, EV_NONE, 8'h00, 1'b0));
    plan.push_back(known_row(32'd50, 1'b0, 1'b1, 8'h0C, EV_POWER_LONG, 8'h0C, 1'b1));
    plan.push_back(known_row(32'd100, 1'b0, 1'b0, 8'hFF, EV_NONE, 8'h00, 1'b0));
    plan.push_back(known_row(32'd150, 1'b0, 1'b1, 8'h08, EV_POWER_SHORT, 8'h08, 1'b1));
    plan.push_back(known_row(32'd200, 1'b0, 1'b1, 8'hF3, EV_NONE, 8'h00, 1'b1));
    plan.push_back(poll_row(32'd210, 1'b1, 1'b1, 8'hFF));
    plan.push_back(poll_row(32'd245, 1'b1, 1'b1, 8'h0C));
    plan.push_back(poll_row(32'd250, 1'b1, 1'b1, 8'h04));
    plan.push_back(known_row(32'd1245, 1'b1, 1'b1, 8'h0C, EV_BUTTON_LONG, 8'h00, 1'b0));
    plan.push_back(poll_row(32'd1246, 1'b1, 1'b1, 8'h0C));
    plan.push_back(poll_row(32'd1300, 1'b0, 1'b1, 8'h00));
    plan.push_back(poll_row(32'd1335, 1'b0, 1'b1, 8'h0C));
    plan.push_back(poll_row(32'd1400, 1'b1, 1'b0, 8'hFF));
    plan.push_back(poll_row(32'd1435, 1'b1, 1'b1, 8'h0C));
    plan.push_back(poll_row(32'd1500, 1'b0, 1'b1, 8'h0C));
    plan.push_back(known_row(32'd1535, 1'b0, 1'b1, 8'h0C, EV_BUTTON_SHORT, 8'h00, 1'b0));
    plan.push_back(poll_row(32'd1600, 1'b1, 1'b1, 8'h00));
    plan.push_back(poll_row(32'd1601, 1'b0, 1'b1, 8'h00));
    plan.push_back(poll_row(32'd1700, 1'b0, 1'b1, 8'h0C));
    plan.push_back(poll_row(32'hFFFF_FFF0, 1'b1, 1'b1, 8'h00));
    plan.push_back(poll_row(32'h0000_0013, 1'b1, 1'b1, 8'h0C));
    plan.push_back(setting_row(mk_cfg(0, 0, 0, 1'b1)));
    plan.push_back(known_row(32'h100, 1'b1, 1'b1, 8'h0C, EV_BUTTON_LONG, 8'h00, 1'b0));
    plan.push_back(known_row(32'h100, 1'b0, 1'b1, 8'h0C, EV_POWER_LONG, 8'h0C, 1'b1));
    plan.push_back(known_row(32'h100, 1'b0, 1'b1, 8'h08, EV_POWER_SHORT, 8'h08, 1'b1));
    plan.push_back(setting_row(mk_cfg(0, 0, 0, 1'b0)));
    plan.push_back(known_row(32'h101, 1'b0, 1'b1, 8'hFF, EV_NONE, 8'h00, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].is_setting) begin
        apply_setting(plan[i].setting);
      end else begin
        send_poll(plan[i].poll, plan[i].typed, plan[i].want);
      end
    end

    run_phase(mk_cfg(35, 1000, 50, 1'b1), 160, 1'b1, 1'b1, 1'b0);
    run_phase(mk_cfg(0, 0, 0, 1'b1), 160, 1'b0, 1'b0, 1'b0);
    run_phase(mk_cfg(65535, 65535, 65535, 1'b1), 160, 1'b1, 1'b0, 1'b1);
    run_phase(mk_cfg(0, 65535, 65535, 1'b0), 160, 1'b1, 1'b0, 1'b0);
    repeat (4) begin
      run_phase(mk_cfg($urandom_range(0, 60), $urandom_range(0, 600), $urandom_range(0, 80),
                       ($urandom_range(0, 3) != 0)), 160, 1'b1, 1'b0, 1'b0);
    end

    drain_wait();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d polls under %0d register settings, with bursty input and output stalls",
             polls_sent, settings_cnt);
    $display("Results: %0d short, %0d long, %0d power long, %0d power short, %0d samples",
             ev_seen[EV_BUTTON_SHORT], ev_seen[EV_BUTTON_LONG], ev_seen[EV_POWER_LONG],
             ev_seen[EV_POWER_SHORT], samples_seen);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_cnt, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
